// ===== rtl/core/igi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igi_pkg: shared types and codes of the interval grid index
// Operation codes, register indexes, reset values and the controller state type.
// ----------------------------------------------------------------------------
package igi_pkg;

  // operation carried by an input item
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_STAB   = 2'd2,
    MODE_RANGE  = 2'd3
  } mode_e;

  // register indexes (byte address is four times the index)
  localparam logic [1:0] REG_NUM_PART   = 2'd0;
  localparam logic [1:0] REG_EXTENT     = 2'd1;
  localparam logic [1:0] REG_DOMAIN_END = 2'd2;

  // reset values of the registers
  localparam logic [4:0]  RST_NUM_PART   = 5'd16;
  localparam logic [31:0] RST_EXTENT     = 32'd1;
  localparam logic [31:0] RST_DOMAIN_END = 32'hFFFF_FFFF;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SPAN,
    ST_PART,
    ST_SCAN,
    ST_OUT
  } state_e;

endpackage

// ===== rtl/core/igi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igi_ram: single-port synchronous RAM
// One access per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module igi_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write or read the addressed entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

// ===== rtl/core/interval_grid_index.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_grid_index: interval store over equal-width time partitions
// Inserts, removes and stabbing or range queries over copies of intervals
// held in one slot RAM, one row of slots per partition.
// ----------------------------------------------------------------------------
// Steps: accept, restoring division of both times by the extent, span set-up,
// then per spanned partition a partition step and a scan of its stored slots
// (insert writes one slot per partition and does not scan), then the result
// item, which is held while out_stall_i is high.
// One item at a time; the slot RAM port (one slot per cycle) sets the rate.
// Reset clears the fill counts and loads the register defaults; the slot RAM
// is not cleared, as no slot at or above a fill count is ever used.
// ----------------------------------------------------------------------------
module interval_grid_index #(
  parameter int MAX_PARTITIONS      = 16,
  parameter int SLOTS_PER_PARTITION = 256,
  parameter int TIME_BITS           = 32,
  parameter int ID_BITS             = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           mode_i,
  input  logic [TIME_BITS-1:0] start_time_i,
  input  logic [TIME_BITS-1:0] end_time_i,
  input  logic [ID_BITS-1:0]   record_id_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          xor_of_ids_o,
  output logic                 status_o
);

  localparam int TW = TIME_BITS;
  localparam int PW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int KW = (SLOTS_PER_PARTITION > 1) ? $clog2(SLOTS_PER_PARTITION) : 1;
  localparam int FW = $clog2(SLOTS_PER_PARTITION + 1);
  localparam int AW = PW + KW;
  localparam int DW = 2 * TW + ID_BITS;
  localparam int CW = $clog2(TW + 1);
  localparam logic [FW-1:0] SLOTS = FW'(SLOTS_PER_PARTITION);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [4:0]  num_part_q;
  logic [31:0] extent_q;
  logic [31:0] domain_end_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_part_q   <= igi_pkg::RST_NUM_PART;
      extent_q     <= igi_pkg::RST_EXTENT;
      domain_end_q <= igi_pkg::RST_DOMAIN_END;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        igi_pkg::REG_NUM_PART:   num_part_q   <= pwdata[4:0];
        igi_pkg::REG_EXTENT:     extent_q     <= pwdata;
        igi_pkg::REG_DOMAIN_END: domain_end_q <= pwdata;
        default: ;
      endcase
    end
  end

  // return register contents
  always_comb begin
    case (paddr[3:2])
      igi_pkg::REG_NUM_PART:   prdata = {27'd0, num_part_q};
      igi_pkg::REG_EXTENT:     prdata = extent_q;
      igi_pkg::REG_DOMAIN_END: prdata = domain_end_q;
      default:                 prdata = 32'd0;
    endcase
  end

  // effective partition count, extent and domain end
  logic [TW+31:0] extent_w;
  logic [TW+31:0] domain_w;
  logic [TW-1:0]  extent;
  logic [TW-1:0]  domain_end;
  logic [10:0]    nused;
  logic [PW-1:0]  last_p;

  assign extent_w   = {{TW{1'b0}}, extent_q};
  assign domain_w   = {{TW{1'b0}}, domain_end_q};
  assign extent     = (extent_w[TW-1:0] == '0) ? TW'(1) : extent_w[TW-1:0];
  assign domain_end = domain_w[TW-1:0];

  always_comb begin
    if (num_part_q == 5'd0) begin
      nused = 11'd1;
    end else if (32'(num_part_q) > MAX_PARTITIONS) begin
      nused = 11'(MAX_PARTITIONS);
    end else begin
      nused = {6'd0, num_part_q};
    end
  end
  assign last_p = PW'(nused - 11'd1);

  // --------------------------------------------------------------------------
  // Controller and datapath registers
  // --------------------------------------------------------------------------
  igi_pkg::state_e state_q, state_d;
  igi_pkg::mode_e  mode_q;
  logic [TW-1:0]      ts_q, te_q;
  logic [ID_BITS-1:0] id_q;
  logic [TW-1:0]      dvd_s_q, dvd_e_q;
  logic [TW-1:0]      rem_s_q, rem_e_q;
  logic [CW-1:0]      cnt_q;
  logic [PW-1:0]      p_q, sp_q, ep_q;
  logic [TW-1:0]      lb_q;
  logic [FW-1:0]      k_q;
  logic [ID_BITS-1:0] acc_q;
  logic               status_q;
  logic [FW-1:0]      fill_q [MAX_PARTITIONS];

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // one restoring division step for start and end times
  logic [TW:0] trial_s, trial_e;
  logic        ge_s, ge_e;
  assign trial_s = {rem_s_q, dvd_s_q[TW-1]};
  assign trial_e = {rem_e_q, dvd_e_q[TW-1]};
  assign ge_s    = trial_s >= {1'b0, extent};
  assign ge_e    = trial_e >= {1'b0, extent};

  // clamp quotients to partitions in use
  logic [TW+PW-1:0] q_s_w, q_e_w, last_w;
  logic [PW-1:0]    sp_c, ep_c, ep_f;
  logic [TW:0]      lb_first;
  assign q_s_w  = {{PW{1'b0}}, dvd_s_q};
  assign q_e_w  = {{PW{1'b0}}, dvd_e_q};
  assign last_w = {{TW{1'b0}}, last_p};
  assign sp_c   = ((ts_q == domain_end) || (q_s_w > last_w)) ? last_p : q_s_w[PW-1:0];
  assign ep_c   = ((te_q == domain_end) || (q_e_w > last_w)) ? last_p : q_e_w[PW-1:0];
  assign ep_f   = ((mode_q == igi_pkg::MODE_STAB) || (ep_c < sp_c)) ? sp_c : ep_c;
  // lower bound of the partition after the start one; unused when sp clamped
  assign lb_first = {1'b0, ts_q - rem_s_q} + {1'b0, extent};

  // slot read back from the RAM
  logic [DW-1:0]      rdata;
  logic [TW-1:0]      sl_start, sl_end;
  logic [ID_BITS-1:0] sl_id;
  assign sl_start = rdata[DW-1 -: TW];
  assign sl_end   = rdata[ID_BITS +: TW];
  assign sl_id    = rdata[ID_BITS-1:0];

  logic [FW-1:0] fill_p;
  logic          part_full, part_empty, last_part;
  logic [FW-1:0] k_nx;
  logic          overlap, fresh, stab_hit, take, rm_hit, part_done;
  assign fill_p     = fill_q[p_q];
  assign part_full  = fill_p >= SLOTS;
  assign part_empty = fill_p == '0;
  assign last_part  = p_q == ep_q;
  assign k_nx       = k_q + FW'(1);
  assign overlap    = (sl_start <= te_q) && (ts_q <= sl_end);
  assign fresh      = sl_start >= lb_q;
  assign stab_hit   = (sl_start <= ts_q) && (ts_q <= sl_end);
  assign rm_hit     = (mode_q == igi_pkg::MODE_REMOVE) && (sl_id == id_q);
  assign part_done  = rm_hit || (k_nx == fill_p);

  always_comb begin
    if (p_q == sp_q) begin
      take = overlap;
    end else if (p_q != ep_q) begin
      take = fresh;
    end else begin
      take = fresh && overlap;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      igi_pkg::ST_IDLE: if (in_acc) state_d = igi_pkg::ST_DIV;
      igi_pkg::ST_DIV:  if (cnt_q == CW'(1)) state_d = igi_pkg::ST_SPAN;
      igi_pkg::ST_SPAN: state_d = igi_pkg::ST_PART;
      igi_pkg::ST_PART: begin
        if (mode_q == igi_pkg::MODE_INSERT || part_empty) begin
          if (last_part) state_d = igi_pkg::ST_OUT;
        end else begin
          state_d = igi_pkg::ST_SCAN;
        end
      end
      igi_pkg::ST_SCAN: begin
        if (part_done) state_d = last_part ? igi_pkg::ST_OUT : igi_pkg::ST_PART;
      end
      igi_pkg::ST_OUT:  if (!out_stall_i) state_d = igi_pkg::ST_IDLE;
      default:          state_d = igi_pkg::ST_IDLE;
    endcase
  end

  // RAM control and handshake outputs
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [DW-1:0] ram_wdata;
  always_comb begin
    ram_we      = 1'b0;
    ram_addr    = {p_q, KW'(0)};
    ram_wdata   = {ts_q, te_q, id_q};
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      igi_pkg::ST_IDLE: in_stall_o = 1'b0;
      igi_pkg::ST_PART: begin
        if (mode_q == igi_pkg::MODE_INSERT) begin
          ram_we   = !part_full;
          ram_addr = {p_q, fill_p[KW-1:0]};
        end
      end
      igi_pkg::ST_SCAN: begin
        if (rm_hit) begin
          ram_we    = 1'b1;
          ram_addr  = {p_q, k_q[KW-1:0]};
          ram_wdata = {sl_start, sl_end, {ID_BITS{1'b0}}};
        end else begin
          ram_addr = {p_q, k_nx[KW-1:0]};
        end
      end
      igi_pkg::ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // hold the state and the partition fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= igi_pkg::ST_IDLE;
      for (int i = 0; i < MAX_PARTITIONS; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (ram_we && state_q == igi_pkg::ST_PART) begin
        fill_q[p_q] <= fill_p + FW'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      igi_pkg::ST_IDLE: begin
        if (in_acc) begin
          mode_q   <= igi_pkg::mode_e'(mode_i);
          ts_q     <= start_time_i;
          te_q     <= end_time_i;
          id_q     <= record_id_i;
          dvd_s_q  <= start_time_i;
          dvd_e_q  <= end_time_i;
          rem_s_q  <= '0;
          rem_e_q  <= '0;
          cnt_q    <= CW'(TW);
          acc_q    <= '0;
          status_q <= 1'b0;
        end
      end
      igi_pkg::ST_DIV: begin
        // shift in one quotient bit per cycle
        rem_s_q <= ge_s ? TW'(trial_s - {1'b0, extent}) : trial_s[TW-1:0];
        rem_e_q <= ge_e ? TW'(trial_e - {1'b0, extent}) : trial_e[TW-1:0];
        dvd_s_q <= {dvd_s_q[TW-2:0], ge_s};
        dvd_e_q <= {dvd_e_q[TW-2:0], ge_e};
        cnt_q   <= cnt_q - CW'(1);
      end
      igi_pkg::ST_SPAN: begin
        // latch the span and start at the first spanned partition
        sp_q <= sp_c;
        ep_q <= ep_f;
        p_q  <= sp_c;
        lb_q <= lb_first[TW-1:0];
      end
      igi_pkg::ST_PART: begin
        if (mode_q == igi_pkg::MODE_INSERT && part_full) begin
          status_q <= 1'b1;
        end
        if (mode_q == igi_pkg::MODE_INSERT || part_empty) begin
          if (!last_part) begin
            p_q  <= p_q + PW'(1);
            lb_q <= (p_q == sp_q) ? lb_q : TW'({1'b0, lb_q} + {1'b0, extent});
          end
        end else begin
          k_q <= '0;
        end
      end
      igi_pkg::ST_SCAN: begin
        if (mode_q == igi_pkg::MODE_STAB && stab_hit) begin
          acc_q <= acc_q ^ sl_id;
        end
        if (mode_q == igi_pkg::MODE_RANGE && take) begin
          acc_q <= acc_q ^ sl_id;
        end
        k_q <= k_nx;
        if (part_done && !last_part) begin
          p_q  <= p_q + PW'(1);
          lb_q <= (p_q == sp_q) ? lb_q : TW'({1'b0, lb_q} + {1'b0, extent});
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Slot memory
  // --------------------------------------------------------------------------
  igi_ram #(
    .WIDTH (DW),
    .DEPTH (2 ** AW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rdata)
  );

  // result item
  logic [ID_BITS+31:0] acc_w;
  assign acc_w        = {32'd0, acc_q};
  assign xor_of_ids_o = acc_w[31:0];
  assign status_o     = status_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ram_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == igi_pkg::ST_PART || state_q == igi_pkg::ST_SCAN))
    else $error("slot RAM written outside partition work");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == igi_pkg::ST_PART) |-> (fill_p <= SLOTS))
    else $error("partition fill beyond slot count");

  a_status_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (mode_q == igi_pkg::MODE_INSERT))
    else $error("overflow status on a non-insert item");

  a_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == igi_pkg::ST_DIV))
    else $error("accepted item did not start division");

endmodule
